FILE: rtl/core/utf8_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Concurrent assertion helpers, removed from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Checks an implication property on the rising clock edge, outside reset.
`define UTF8SD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("utf8_stream_decoder: assertion failed");

// Checks that a condition never holds on the rising clock edge.
`define UTF8SD_NEVER(label, clk, rst_n, cond) \
    `UTF8SD_ASSERT(label, clk, rst_n, !(cond))

`else

`define UTF8SD_ASSERT(label, clk, rst_n, prop)
`define UTF8SD_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/core/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types, constants and the lead and continuation byte classification functions.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    // Depth of the pending byte buffer.
    localparam int unsigned PendDepth = 4;

    // Byte classification constants.
    localparam logic [7:0] LeadMask2 = 8'he0;
    localparam logic [7:0] LeadCode2 = 8'hc0;
    localparam logic [7:0] LeadMask3 = 8'hf0;
    localparam logic [7:0] LeadCode3 = 8'he0;
    localparam logic [7:0] LeadMask4 = 8'hf8;
    localparam logic [7:0] LeadCode4 = 8'hf0;
    localparam logic [7:0] ContLow   = 8'h80;
    localparam logic [7:0] ContHigh  = 8'hbf;

    // Surrogate range of code points.
    localparam logic [20:0] SurrLow  = 21'h00d800;
    localparam logic [20:0] SurrHigh = 21'h00dfff;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    // Pending buffer control from the sequencer.
    typedef struct packed {
        logic       append;
        logic       drop;
        logic [2:0] drop_len;
        logic       clear;
    } t_buf_ctrl;

    // Result of one evaluation of the head of the buffer.
    typedef struct packed {
        logic        emit;
        logic [20:0] cp;
        logic [2:0]  len;
        logic        err;
    } t_eval_res;

    // Sequence length given by a lead byte; zero for an invalid lead.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (!b[7]) begin
            len = 3'd1;
        end else if ((b & LeadMask2) == LeadCode2) begin
            len = 3'd2;
        end else if ((b & LeadMask3) == LeadCode3) begin
            len = 3'd3;
        end else if ((b & LeadMask4) == LeadCode4) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // True for a continuation byte.
    function automatic logic is_cont(input logic [7:0] b);
        return (b >= ContLow) && (b <= ContHigh);
    endfunction

endpackage

FILE: rtl/core/utf8sd_buf.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder pending buffer
// Holds up to four bytes, oldest first; appends at the tail and drops from
// the head.
// ----------------------------------------------------------------------------
module utf8sd_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  utf8sd_pkg::t_buf_ctrl i_ctrl,
    input  logic [7:0]           i_byte,
    output logic [7:0]           o_bytes [utf8sd_pkg::PendDepth],
    output logic [2:0]           o_count
);

    logic [7:0] r_bytes [utf8sd_pkg::PendDepth];
    logic [7:0] n_bytes [utf8sd_pkg::PendDepth];
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic [1:0] w_tail;

    // Tail position; the count never exceeds three between bytes.
    assign w_tail = (r_count >= 3'd4) ? 2'd3 : r_count[1:0];

    // Next contents: append, shift forward by the dropped length, or clear.
    always_comb begin
        logic [2:0] sel;
        sel     = 3'd0;
        n_bytes = r_bytes;
        n_count = r_count;
        if (i_ctrl.append) begin
            n_bytes[w_tail] = i_byte;
            n_count         = {1'b0, w_tail} + 3'd1;
        end else if (i_ctrl.drop) begin
            for (int i = 0; i < utf8sd_pkg::PendDepth; i++) begin
                sel = 3'(i) + i_ctrl.drop_len;
                if (sel < 3'd4) begin
                    n_bytes[i[1:0]] = r_bytes[sel[1:0]];
                end
            end
            n_count = (i_ctrl.drop_len >= r_count) ? 3'd0 : r_count - i_ctrl.drop_len;
        end else if (i_ctrl.clear) begin
            n_count = 3'd0;
        end
    end

    // Byte storage carries no reset.
    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_bytes = r_bytes;
    assign o_count = r_count;

endmodule

FILE: rtl/core/utf8sd_eval.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder evaluation unit
// Decodes the sequence at the head of the pending buffer, once per cycle.
// ----------------------------------------------------------------------------
module utf8sd_eval (
    input  logic                  [7:0] i_bytes [utf8sd_pkg::PendDepth],
    input  logic                  [2:0] i_count,
    input  logic                        i_end,
    output utf8sd_pkg::t_eval_res       o_res
);

    logic [7:0]  w_lead;
    logic [2:0]  w_len;
    logic [20:0] w_cp;
    logic        w_cont_ok;
    logic        w_surr;

    assign w_lead = i_bytes[0];
    assign w_len  = utf8sd_pkg::lead_length(w_lead);

    // Assemble the code point and check the continuation bytes.
    always_comb begin
        w_cp      = '0;
        w_cont_ok = 1'b1;
        case (w_len)
            3'd1: begin
                w_cp = {13'd0, w_lead};
            end
            3'd2: begin
                w_cp      = {10'd0, w_lead[4:0], i_bytes[1][5:0]};
                w_cont_ok = utf8sd_pkg::is_cont(i_bytes[1]);
            end
            3'd3: begin
                w_cp      = {5'd0, w_lead[3:0], i_bytes[1][5:0], i_bytes[2][5:0]};
                w_cont_ok = utf8sd_pkg::is_cont(i_bytes[1])
                          & utf8sd_pkg::is_cont(i_bytes[2]);
            end
            3'd4: begin
                w_cp      = {w_lead[2:0], i_bytes[1][5:0], i_bytes[2][5:0],
                             i_bytes[3][5:0]};
                w_cont_ok = utf8sd_pkg::is_cont(i_bytes[1])
                          & utf8sd_pkg::is_cont(i_bytes[2])
                          & utf8sd_pkg::is_cont(i_bytes[3]);
            end
            default: begin
                w_cp      = '0;
                w_cont_ok = 1'b0;
            end
        endcase
    end

    assign w_surr = (w_cp >= utf8sd_pkg::SurrLow) && (w_cp <= utf8sd_pkg::SurrHigh);

    // Classify the head: valid sequence, error, or still waiting for bytes.
    always_comb begin
        o_res = '0;
        if (i_count != 3'd0) begin
            if (w_len == 3'd0) begin
                o_res.emit = 1'b1;
                o_res.err  = 1'b1;
            end else if (i_count < w_len) begin
                o_res.emit = i_end;
                o_res.err  = 1'b1;
            end else begin
                o_res.emit = 1'b1;
                o_res.err  = !w_cont_ok || w_surr;
            end
            if (o_res.err) begin
                o_res.cp  = '0;
                o_res.len = 3'd1;
            end else begin
                o_res.cp  = w_cp;
                o_res.len = w_len;
            end
        end
    end

endmodule

FILE: rtl/core/utf8_stream_decoder.sv
// Path: a taken byte waits in the pending buffer; each of its results goes through the
// held result register and the output register. A byte that yields k results (0 to 4)
// is taken in idle, then gets one evaluation pass per result plus a final empty pass.
// The single evaluation unit decodes one sequence per cycle; a stalled m_axis holds it.
// Reset: i_rst_n is synchronous and active low; it empties the pending buffer and the
// output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes UTF-8 bytes into code points, taking a byte only once the one before is done.
// Error items mark invalid leads and continuations, surrogates and cut sequences.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // stream_end
    // Code point output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] seq_length
    output logic [1:0]  m_axis_tuser,   // [0] is_error, [1] end_of_stream
    output logic        m_axis_tlast    // end_of_run
);

    utf8sd_pkg::t_state    r_state;
    utf8sd_pkg::t_state    n_state;
    utf8sd_pkg::t_buf_ctrl w_ctrl;
    utf8sd_pkg::t_eval_res w_res;

    logic [7:0]  w_bytes [utf8sd_pkg::PendDepth];
    logic [2:0]  w_count;

    logic        r_end;
    logic        n_end;

    // Held result, waiting to learn whether it is the last of its byte.
    logic        r_hold_vld;
    logic        n_hold_vld;
    logic [20:0] r_hold_cp;
    logic [20:0] n_hold_cp;
    logic [2:0]  r_hold_len;
    logic [2:0]  n_hold_len;
    logic        r_hold_err;
    logic        n_hold_err;

    // Output register.
    logic        r_out_vld;
    logic        n_out_vld;
    logic [20:0] r_out_cp;
    logic [20:0] n_out_cp;
    logic [2:0]  r_out_len;
    logic [2:0]  n_out_len;
    logic        r_out_err;
    logic        n_out_err;
    logic        r_out_eor;
    logic        n_out_eor;
    logic        r_out_eos;
    logic        n_out_eos;

    logic        w_in_xfer;
    logic        w_out_free;
    logic        w_step;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_vld || m_axis_tready;
    assign w_step     = (r_state == utf8sd_pkg::ST_EVAL) && (!r_hold_vld || w_out_free);

    utf8sd_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_byte  (s_axis_tdata),
        .o_bytes (w_bytes),
        .o_count (w_count)
    );

    utf8sd_eval u_eval (
        .i_bytes (w_bytes),
        .i_count (w_count),
        .i_end   (r_end),
        .o_res   (w_res)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            utf8sd_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = utf8sd_pkg::ST_EVAL;
                end
            end
            utf8sd_pkg::ST_EVAL: begin
                if (w_step && !w_res.emit) begin
                    n_state = utf8sd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = utf8sd_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: buffer control, held result and output register.
    always_comb begin
        s_axis_tready = 1'b0;
        w_ctrl        = '0;
        n_end         = r_end;
        n_hold_vld    = r_hold_vld;
        n_hold_cp     = r_hold_cp;
        n_hold_len    = r_hold_len;
        n_hold_err    = r_hold_err;
        n_out_vld     = r_out_vld && !m_axis_tready;
        n_out_cp      = r_out_cp;
        n_out_len     = r_out_len;
        n_out_err     = r_out_err;
        n_out_eor     = r_out_eor;
        n_out_eos     = r_out_eos;
        case (r_state)
            utf8sd_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_in_xfer) begin
                    w_ctrl.append = 1'b1;
                    n_end         = s_axis_tlast;
                end
            end
            utf8sd_pkg::ST_EVAL: begin
                if (w_step) begin
                    // Pass the held result on; it is the last one when nothing follows.
                    if (r_hold_vld) begin
                        n_out_vld = 1'b1;
                        n_out_cp  = r_hold_cp;
                        n_out_len = r_hold_len;
                        n_out_err = r_hold_err;
                        n_out_eor = !w_res.emit;
                        n_out_eos = !w_res.emit && r_end;
                    end
                    if (w_res.emit) begin
                        n_hold_vld      = 1'b1;
                        n_hold_cp       = w_res.cp;
                        n_hold_len      = w_res.len;
                        n_hold_err      = w_res.err;
                        w_ctrl.drop     = 1'b1;
                        w_ctrl.drop_len = w_res.len;
                    end else begin
                        n_hold_vld   = 1'b0;
                        w_ctrl.clear = r_end;
                    end
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= utf8sd_pkg::ST_IDLE;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_end      <= n_end;
        r_hold_cp  <= n_hold_cp;
        r_hold_len <= n_hold_len;
        r_hold_err <= n_hold_err;
        r_out_cp   <= n_out_cp;
        r_out_len  <= n_out_len;
        r_out_err  <= n_out_err;
        r_out_eor  <= n_out_eor;
        r_out_eos  <= n_out_eos;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_len, r_out_cp};
    assign m_axis_tuser  = {r_out_eos, r_out_err};
    assign m_axis_tlast  = r_out_eor;

    // A new byte is taken only once every result of the previous one has left the hold.
    `UTF8SD_NEVER(a_ready_hold_empty, i_clk, i_rst_n, s_axis_tready && r_hold_vld)
    // Between bytes the buffer never holds a complete four-byte backlog.
    `UTF8SD_ASSERT(a_idle_count, i_clk, i_rst_n,
        (r_state == utf8sd_pkg::ST_IDLE) |-> (w_count <= 3'd3))
    // An error transaction carries a zero code point and a length of one.
    `UTF8SD_ASSERT(a_err_shape, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser[0]) |->
        ((m_axis_tdata[20:0] == 21'd0) && (m_axis_tdata[23:21] == 3'd1)))
    // The end of the stream is always the end of a run.
    `UTF8SD_ASSERT(a_eos_eor, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 stream decoder
// Sends directed and random UTF-8 byte streams through the decoder. Each
// accepted byte is decoded by a behavioural model in the bench. Every code
// point transaction is then compared, field by field, with the oldest
// expected item. Both stream sides idle at random in two of the three phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    // One decoded item as it should leave the master side.
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  seq_len;
        logic        is_err;
        logic        run_end;
        logic        stream_end;
    } t_cp_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Idle percentages of the byte sender and the code point receiver.
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;

    // Decoder model state and the items still awaited from the block.
    logic [7:0]  pend_buf [utf8sd_pkg::PendDepth];
    int unsigned pend_cnt = 0;
    t_cp_item    expected_cps [$];

    int unsigned mismatches = 0;
    int unsigned bytes_taken = 0;
    int unsigned items_checked = 0;
    int unsigned error_items = 0;
    int unsigned stream_ends = 0;

    utf8_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, well above the slowest correct run.
    initial begin
        #5_000_000;
        $display("[utf8_stream_decoder] ERROR");
        $finish;
    end

    // Sequence length announced by a lead byte; zero for a byte that cannot lead.
    function automatic int seq_len_of_lead(input logic [7:0] b);
        int len;
        if (!b[7]) begin
            len = 1;
        end else if (b[7:5] == 3'b110) begin
            len = 2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3;
        end else if (b[7:3] == 5'b11110) begin
            len = 4;
        end else begin
            len = 0;
        end
        return len;
    endfunction

    // Appends one byte to the pending bytes and decodes every sequence it completes.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        t_cp_item    run_items [utf8sd_pkg::PendDepth];
        int          n_items;
        int          n;
        int          i;
        logic [20:0] cp;
        logic        bad;
        logic [7:0]  c;
        n_items = 0;
        if (pend_cnt >= utf8sd_pkg::PendDepth) begin
            pend_cnt = utf8sd_pkg::PendDepth - 1;
        end
        pend_buf[pend_cnt] = b;
        pend_cnt++;
        while (pend_cnt > 0 && n_items < utf8sd_pkg::PendDepth) begin
            n = seq_len_of_lead(pend_buf[0]);
            cp = '0;
            bad = 1'b0;
            if (n == 0) begin
                bad = 1'b1;
            end else if (pend_cnt < n) begin
                if (!last) break;
                bad = 1'b1;
            end else begin
                case (n)
                    1: cp = 21'(pend_buf[0]);
                    2: cp = 21'({pend_buf[0][4:0], 6'b0});
                    3: cp = 21'({pend_buf[0][3:0], 12'b0});
                    default: cp = 21'({pend_buf[0][2:0], 18'b0});
                endcase
                for (i = 1; i < n; i++) begin
                    c = pend_buf[i];
                    if (c < utf8sd_pkg::ContLow || c > utf8sd_pkg::ContHigh) bad = 1'b1;
                    cp = cp | (21'(c[5:0]) << (6 * (n - 1 - i)));
                end
                if (cp >= utf8sd_pkg::SurrLow && cp <= utf8sd_pkg::SurrHigh) bad = 1'b1;
            end
            // An invalid sequence gives up only its first byte.
            if (bad) begin
                cp = '0;
                n = 1;
            end
            run_items[n_items] = '{cp, 3'(n), bad, 1'b0, 1'b0};
            n_items++;
            for (i = 0; i + n < pend_cnt; i++) begin
                pend_buf[i] = pend_buf[i + n];
            end
            pend_cnt = (n >= pend_cnt) ? 0 : pend_cnt - n;
        end
        if (n_items > 0) begin
            run_items[n_items - 1].run_end = 1'b1;
            run_items[n_items - 1].stream_end = last;
        end
        for (i = 0; i < n_items; i++) begin
            expected_cps.push_back(run_items[i]);
        end
        if (last) pend_cnt = 0;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h",
                 $realtime, what, want, got);
        mismatches++;
    endtask

    // Compares one code point transaction with the oldest expected item.
    task automatic check_code_point();
        t_cp_item want;
        items_checked++;
        if (m_axis_tuser[0]) error_items++;
        if (m_axis_tuser[1]) stream_ends++;
        if (expected_cps.size() == 0) begin
            report_mismatch("unexpected transaction", 0, m_axis_tdata);
        end else begin
            want = expected_cps.pop_front();
            if (m_axis_tdata[20:0] !== want.code_point)
                report_mismatch("code_point", want.code_point, m_axis_tdata[20:0]);
            if (m_axis_tdata[23:21] !== want.seq_len)
                report_mismatch("seq_length", want.seq_len, m_axis_tdata[23:21]);
            if (m_axis_tuser[0] !== want.is_err)
                report_mismatch("is_error", want.is_err, m_axis_tuser[0]);
            if (m_axis_tlast !== want.run_end)
                report_mismatch("end_of_run", want.run_end, m_axis_tlast);
            if (m_axis_tuser[1] !== want.stream_end)
                report_mismatch("end_of_stream", want.stream_end, m_axis_tuser[1]);
        end
    endtask

    // Output is checked before the byte of the same edge is decoded.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_tready) check_code_point();
            if (s_tvalid && s_axis_tready) begin
                decode_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Offers one byte and returns at the falling edge after its transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
    endtask

    // Two, three and four byte forms, the largest code point and an overlong form.
    task automatic test_multibyte();
        send_byte(8'hc2, 1'b0);
        send_byte(8'ha9, 1'b0);
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hac, 1'b0);
        send_byte(8'hf7, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hc0, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_invalid_leads();
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
    endtask

    // The encoded surrogate fails, then each of its trailing bytes fails alone.
    task automatic test_surrogate();
        send_byte(8'hed, 1'b0);
        send_byte(8'ha0, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_bad_continuation();
        send_byte(8'hc3, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    // A stream that ends inside a sequence, then a one-byte stream.
    task automatic test_early_end();
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    // Mostly well-formed sequences with random content, plus noise, cut and
    // broken sequences; now and then the stream ends on the last byte.
    task automatic test_random_stream(input int unsigned n_bytes);
        logic [7:0]  seq [$];
        int unsigned sent;
        int          kind;
        int          len;
        int          i;
        int          pos;
        logic        end_mark;
        sent = 0;
        while (sent < n_bytes) begin
            seq.delete();
            kind = $urandom_range(0, 99);
            if (kind < 65) len = $urandom_range(1, 4);
            else if (kind < 75) len = 1;
            else len = $urandom_range(2, 4);
            case (len)
                1: seq.push_back(8'($urandom_range(0, 127)));
                2: seq.push_back(utf8sd_pkg::LeadCode2 | 8'($urandom_range(0, 31)));
                3: seq.push_back(utf8sd_pkg::LeadCode3 | 8'($urandom_range(0, 15)));
                default: seq.push_back(utf8sd_pkg::LeadCode4 | 8'($urandom_range(0, 7)));
            endcase
            for (i = 1; i < len; i++) begin
                seq.push_back(utf8sd_pkg::ContLow | 8'($urandom_range(0, 63)));
            end
            if (kind >= 65 && kind < 75) begin
                seq[0] = 8'($urandom_range(0, 255));
            end else if (kind >= 75 && kind < 85) begin
                // Cut short: the next sequence or the stream end breaks it.
                pos = $urandom_range(1, len - 1);
                while (seq.size() > pos) void'(seq.pop_back());
            end else if (kind >= 85) begin
                pos = $urandom_range(1, len - 1);
                seq[pos] = $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                : 8'($urandom_range(192, 255));
            end
            end_mark = ($urandom_range(0, 9) == 0);
            for (i = 0; i < seq.size(); i++) begin
                send_byte(seq[i], end_mark && (i == seq.size() - 1));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Slow receiver, mostly busy sender.
        src_idle_pct = 16;
        snk_idle_pct = 82;
        test_single_bytes();
        test_multibyte();
        test_invalid_leads();
        test_surrogate();
        test_bad_continuation();
        test_early_end();
        test_random_stream(60);

        // Slow sender, mostly ready receiver.
        src_idle_pct = 82;
        snk_idle_pct = 16;
        test_random_stream(60);

        // Full rate on both sides.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_stream(60);
        s_tvalid <= 1'b0;

        while (expected_cps.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Decoded %0d bytes into %0d code point items (%0d errors, %0d stream ends).",
                 bytes_taken, items_checked, error_items, stream_ends);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0) begin
            $display("[utf8_stream_decoder] OK");
        end else begin
            $display("[utf8_stream_decoder] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/utf8sd_pkg.sv
rtl/core/utf8sd_buf.sv
rtl/core/utf8sd_eval.sv
rtl/core/utf8_stream_decoder.sv
bench/testbench.sv
